[rtl/cmt_pkg.sv]
// Shared types and constants for the character-set mapping table.
// Used by the controller, the datapath and the top level; no dependencies.

package cmt_pkg;

   // Sizes of the flat narrow table and the block pointer table.
   localparam int NARROW_DEPTH = 256;
   localparam int NARROW_W     = 8;
   localparam int WIDE_W       = 16;
   localparam int ENTRY_W      = NARROW_W + 1;
   localparam int BLOCKS_DEFAULT = 16;

   // A wide code of all ones means "no mapping".
   localparam logic [WIDE_W-1:0] NONE16 = 16'hFFFF;

   // Opcodes of an input item.
   localparam logic [1:0] OP_ADD_PAIR = 2'd0;
   localparam logic [1:0] OP_N2W      = 2'd1;
   localparam logic [1:0] OP_W2N      = 2'd2;

   // Result status codes.
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_DEFAULT  = 2'd1;
   localparam logic [1:0] STAT_UNMAPPED = 2'd2;
   localparam logic [1:0] STAT_NO_BLOCK = 2'd3;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDE_DEFAULT      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDE_DEFAULT_ON   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NARROW_DEFAULT    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NARROW_DEFAULT_ON = 2'd3;

   // Input item.
   typedef struct packed {
      logic [1:0]          opcode;
      logic [NARROW_W-1:0] narrow_code;
      logic [WIDE_W-1:0]   wide_code;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [WIDE_W-1:0] mapped_code;
      logic [1:0]        status;
   } rsp_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK1,
      ST_LOOK2,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_en;
      logic take;
      logic look1;
      logic look2;
      logic load_out;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic need_look2;
      logic out_free;
   } ctl_stat_type;

endpackage

[rtl/cmt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module cmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/cmt_ctrl.sv]
// Sequencing state machine of the character-set mapping table.
// Depends on cmt_pkg for the state type and the command and status structs.

module cmt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cmt_pkg::ctl_stat_type stat,
   output cmt_pkg::ctl_cmd_type  cmd
);
   import cmt_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOOK1;
            end
         end
         ST_LOOK1: begin
            state_in = stat.need_look2 ? ST_LOOK2 : ST_DONE;
         end
         ST_LOOK2: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         ST_LOOK1: begin
            cmd.look1 = 1'b1;
         end
         ST_LOOK2: begin
            cmd.look2 = 1'b1;
         end
         ST_DONE: begin
            cmd.load_out = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[rtl/cmt_datapath.sv]
// Datapath of the character-set mapping table: configuration registers,
// the three table memories, the block allocator and the result registers.
// Depends on cmt_pkg and cmt_ram.

module cmt_datapath #(
   parameter int BLOCKS = cmt_pkg::BLOCKS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cmt_pkg::req_type                     req_data,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output cmt_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   input  logic [cmt_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cmt_pkg::WIDE_W-1:0]           csr_wdata,
   input  cmt_pkg::ctl_cmd_type                 cmd,
   output cmt_pkg::ctl_stat_type                stat
);
   import cmt_pkg::*;

   localparam int IDX_W       = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
   localparam int USED_W      = $clog2(BLOCKS + 1);
   localparam int STORE_DEPTH = BLOCKS * NARROW_DEPTH;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int PTR_W       = IDX_W + 1;

   // Configuration registers.
   logic [WIDE_W-1:0]   wide_default_ff;
   logic                wide_default_on_ff;
   logic [NARROW_W-1:0] narrow_default_ff;
   logic                narrow_default_on_ff;

   // Control state.
   logic [STORE_AW-1:0] clr_cnt_ff;
   logic [USED_W-1:0]   used_ff;
   logic                rsp_valid_ff;

   // Payload registers.
   req_type             item_ff;
   logic [IDX_W-1:0]    blk_ff;
   rsp_type             res_ff;
   rsp_type             res_in;
   rsp_type             rsp_data_ff;

   // Memory ports.
   logic                n2w_wr_en;
   logic [NARROW_W-1:0] n2w_wr_addr;
   logic [WIDE_W-1:0]   n2w_wr_data;
   logic [WIDE_W-1:0]   n2w_rd;
   logic                bp_wr_en;
   logic [NARROW_W-1:0] bp_wr_addr;
   logic [PTR_W-1:0]    bp_wr_data;
   logic [PTR_W-1:0]    bp_rd;
   logic                st_wr_en;
   logic [STORE_AW-1:0] st_wr_addr;
   logic [ENTRY_W-1:0]  st_wr_data;
   logic [STORE_AW-1:0] st_rd_addr;
   logic [ENTRY_W-1:0]  st_rd;

   // First lookup stage decisions.
   logic                clr_low;
   logic                wide_none;
   logic                bp_valid;
   logic                blocks_full;
   logic                n2w_hit;
   logic                need2_c;
   logic                add_go_c;
   logic                alloc_c;
   logic [IDX_W-1:0]    blk_c;
   rsp_type             res1_c;
   rsp_type             res2_c;
   rsp_type             wide_miss;
   rsp_type             narrow_miss;
   logic                st_write_c;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         wide_default_ff      <= '0;
         wide_default_on_ff   <= 1'b0;
         narrow_default_ff    <= '0;
         narrow_default_on_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WIDE_DEFAULT:      wide_default_ff      <= csr_wdata;
            CSR_WIDE_DEFAULT_ON:   wide_default_on_ff   <= csr_wdata[0];
            CSR_NARROW_DEFAULT:    narrow_default_ff    <= csr_wdata[NARROW_W-1:0];
            CSR_NARROW_DEFAULT_ON: narrow_default_on_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Clearing sweep counter; the small tables are cleared while it is below NARROW_DEPTH.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_en) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   assign clr_low         = ({1'b0, clr_cnt_ff} < (STORE_AW + 1)'(NARROW_DEPTH));
   assign stat.clear_last = (clr_cnt_ff == STORE_AW'(STORE_DEPTH - 1));

   // Item register.
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         item_ff <= req_data;
      end
   end

   // Miss results for both directions.
   always_comb begin
      if (wide_default_on_ff) begin
         wide_miss = '{mapped_code: wide_default_ff, status: STAT_DEFAULT};
      end else begin
         wide_miss = '{mapped_code: '0, status: STAT_UNMAPPED};
      end
      if (narrow_default_on_ff) begin
         narrow_miss = '{mapped_code: {8'd0, narrow_default_ff}, status: STAT_DEFAULT};
      end else begin
         narrow_miss = '{mapped_code: '0, status: STAT_UNMAPPED};
      end
   end

   assign wide_none   = (item_ff.wide_code == NONE16);
   assign bp_valid    = bp_rd[IDX_W];
   assign blocks_full = (used_ff == USED_W'(BLOCKS));
   assign n2w_hit     = (n2w_rd != NONE16);

   // First stage: flat table and block pointer data are ready.
   always_comb begin
      need2_c  = 1'b0;
      add_go_c = 1'b0;
      alloc_c  = 1'b0;
      blk_c    = bp_rd[IDX_W-1:0];
      res1_c   = '{mapped_code: '0, status: STAT_UNMAPPED};
      case (item_ff.opcode)
         OP_ADD_PAIR: begin
            res1_c = '{mapped_code: '0, status: STAT_OK};
            if (!wide_none) begin
               if (!bp_valid && blocks_full) begin
                  res1_c.status = STAT_NO_BLOCK;
               end else begin
                  need2_c  = 1'b1;
                  add_go_c = 1'b1;
                  alloc_c  = !bp_valid;
                  if (!bp_valid) begin
                     blk_c = IDX_W'(used_ff);
                  end
               end
            end
         end
         OP_N2W: begin
            if (n2w_hit) begin
               res1_c = '{mapped_code: n2w_rd, status: STAT_OK};
            end else begin
               res1_c = wide_miss;
            end
         end
         OP_W2N: begin
            if (!wide_none && bp_valid) begin
               need2_c = 1'b1;
            end else begin
               res1_c = narrow_miss;
            end
         end
         default: begin
            res1_c = '{mapped_code: '0, status: STAT_UNMAPPED};
         end
      endcase
   end

   assign stat.need_look2 = need2_c;

   // Second stage: block store entry is ready.
   always_comb begin
      res2_c     = res_ff;
      st_write_c = 1'b0;
      case (item_ff.opcode)
         OP_W2N: begin
            if (st_rd[NARROW_W]) begin
               res2_c = '{mapped_code: {8'd0, st_rd[NARROW_W-1:0]}, status: STAT_OK};
            end else begin
               res2_c = narrow_miss;
            end
         end
         OP_ADD_PAIR: begin
            st_write_c = !st_rd[NARROW_W];
         end
         default: begin
            res2_c = res_ff;
         end
      endcase
   end

   // Block allocator and pending result.
   always_comb begin
      res_in = res_ff;
      if (cmd.look1) begin
         res_in = res1_c;
      end else if (cmd.look2) begin
         res_in = res2_c;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (cmd.look1) begin
         blk_ff <= blk_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.look1 && add_go_c && alloc_c) begin
         used_ff <= used_ff + 1'b1;
      end
   end

   // Flat narrow-to-wide table.
   assign n2w_wr_en   = (cmd.clear_en && clr_low) || (cmd.look1 && add_go_c && !n2w_hit);
   assign n2w_wr_addr = cmd.clear_en ? clr_cnt_ff[NARROW_W-1:0] : item_ff.narrow_code;
   assign n2w_wr_data = cmd.clear_en ? NONE16 : item_ff.wide_code;

   cmt_ram #(
      .WIDTH (WIDE_W),
      .DEPTH (NARROW_DEPTH)
   ) u_n2w_ram (
      .clock   (clock),
      .wr_en   (n2w_wr_en),
      .wr_addr (n2w_wr_addr),
      .wr_data (n2w_wr_data),
      .rd_en   (cmd.take),
      .rd_addr (req_data.narrow_code),
      .rd_data (n2w_rd)
   );

   // Block pointer table: valid bit over block index.
   assign bp_wr_en   = (cmd.clear_en && clr_low) || (cmd.look1 && add_go_c && alloc_c);
   assign bp_wr_addr = cmd.clear_en ? clr_cnt_ff[NARROW_W-1:0] : item_ff.wide_code[15:8];
   assign bp_wr_data = cmd.clear_en ? '0 : {1'b1, IDX_W'(used_ff)};

   cmt_ram #(
      .WIDTH (PTR_W),
      .DEPTH (NARROW_DEPTH)
   ) u_bp_ram (
      .clock   (clock),
      .wr_en   (bp_wr_en),
      .wr_addr (bp_wr_addr),
      .wr_data (bp_wr_data),
      .rd_en   (cmd.take),
      .rd_addr (req_data.wide_code[15:8]),
      .rd_data (bp_rd)
   );

   // Block store: valid bit over narrow byte.
   assign st_rd_addr = STORE_AW'({blk_c, item_ff.wide_code[7:0]});
   assign st_wr_en   = cmd.clear_en || (cmd.look2 && st_write_c);
   assign st_wr_addr = cmd.clear_en ? clr_cnt_ff
                                    : STORE_AW'({blk_ff, item_ff.wide_code[7:0]});
   assign st_wr_data = cmd.clear_en ? '0 : {1'b1, item_ff.narrow_code};

   cmt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STORE_DEPTH)
   ) u_store_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (cmd.look1),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;

endmodule

[rtl/charset_map_table.sv]
// Top level of the character-set mapping table: controller plus datapath.
// Depends on cmt_pkg, cmt_ctrl, cmt_datapath and cmt_ram.

// Translates between an 8-bit code page and 16-bit codes, one item at a time.
// After reset the block sweeps its tables and takes no item until the sweep
// ends; configuration writes are taken at any time. An item passes through
// the second lookup state when the block store is consulted: an add-pair of a
// wide code whose high byte owns a block or can get a free one, or a
// wide-to-narrow lookup whose high byte owns a block. Every other item skips
// that state: a narrow-to-wide lookup, an unknown opcode, an add-pair with no
// wide code or with no free block, and a wide-to-narrow lookup of no wide code
// or of an unowned high byte. The states follow the registered memory reads:
// the flat table and block pointer are read on acceptance, the block store
// entry in the first lookup state.
// A finished result sits in the output register, and the next item is
// accepted while it waits to be taken; the item after that result stalls
// only if the output register is still full when its own result is ready.

module charset_map_table #(
   parameter int BLOCKS = cmt_pkg::BLOCKS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  cmt_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output cmt_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cmt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cmt_pkg::WIDE_W-1:0]    csr_wdata
);
   import cmt_pkg::*;

   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   // Registers are always writable.
   assign csr_ready = 1'b1;

   cmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cmt_datapath #(
      .BLOCKS (BLOCKS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat)
   );

`ifndef NO_ASSERTIONS
   // A result is never loaded over one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || rsp_ready))
      else $error("result loaded over a waiting item");

   // Only one item is in work at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item accepted while one is in work");

   // Commands to the datapath are mutually exclusive.
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_en, cmd.take, cmd.look1, cmd.look2, cmd.load_out}))
      else $error("overlapping datapath commands");

   // The block store stage always follows the first lookup stage.
   a_look_order: assert property (@(posedge clock) disable iff (reset)
      cmd.look2 |-> $past(cmd.look1))
      else $error("second lookup stage without the first");
`endif

endmodule
